// File: hdl/sbeq_pkg.sv
// shared constants, types and saturation helpers for the stereo biquad equaliser
// no dependencies; imported by every module of the block
package sbeq_pkg;

  localparam int BAND_COUNT  = 8;
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 32;
  localparam int SIG_BITS    = SAMPLE_BITS + 8;
  localparam int COEF_FRAC   = COEF_BITS - 4;
  localparam int PROD_BITS   = COEF_BITS + SIG_BITS;
  localparam int ACC_BITS    = 64;
  localparam int FADE_BITS   = 14;
  localparam int FADE_RESET  = 1440;
  localparam int BAND_W      = 3;
  localparam int COEF_TAPS   = 5;
  localparam int TAP_W       = 3;
  localparam int HTAP_W      = 2;
  localparam int CADDR_W     = 1 + BAND_W + TAP_W;
  localparam int HADDR_W     = 1 + BAND_W + HTAP_W;
  localparam int STEP_W      = 6;
  localparam int PASS_LAST   = 12;
  localparam int COPY_LAST   = 5;
  localparam int WRITE_LAST  = COEF_TAPS - 1;
  localparam int NUM_BITS    = SIG_BITS + 1 + FADE_BITS;
  localparam int DIV_FIRST   = 2;
  localparam int DIV_LAST    = DIV_FIRST + NUM_BITS - 1;
  localparam int MIX_LAST    = DIV_LAST + 1;
  localparam int IN_BITS     = 216;
  localparam int OUT_BITS    = 48;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC;
  localparam logic [ACC_BITS-1:0]  ACC_HALF = ACC_BITS'(1) << (COEF_FRAC - 1);

  typedef enum logic [2:0] {
    M_IDLE, M_LOAD, M_PASS, M_COPY, M_CLEAR, M_MIX, M_COMMIT
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE, S_UPD, S_COPY, S_WRITE, S_BAND, S_PASS_CUR, S_PASS_OLD, S_MIX, S_NEXT, S_OUT
  } state_t;

  typedef struct packed {
    mode_t                 mode;
    logic [STEP_W-1:0]     step;
    logic                  set;
    logic [BAND_W-1:0]     band;
    logic [FADE_BITS-1:0]  w;
    logic [FADE_BITS-1:0]  len;
  } lane_ctl_t;

  function automatic logic signed [ACC_BITS-1:0] sat_add(
      input logic signed [ACC_BITS-1:0] a, input logic signed [ACC_BITS-1:0] b);
    logic signed [ACC_BITS:0] s;
    logic signed [ACC_BITS-1:0] r;
    s = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
    if (s[ACC_BITS] != s[ACC_BITS-1])
      r = s[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
    else
      r = s[ACC_BITS-1:0];
    return r;
  endfunction

  function automatic logic signed [SIG_BITS-1:0] sat_sig(input logic signed [ACC_BITS-1:0] v);
    logic signed [ACC_BITS-1:0] hi;
    logic signed [ACC_BITS-1:0] lo;
    logic signed [SIG_BITS-1:0] r;
    hi = {{(ACC_BITS-SIG_BITS+1){1'b0}}, {(SIG_BITS-1){1'b1}}};
    lo = ~hi;
    if (v > hi)      r = hi[SIG_BITS-1:0];
    else if (v < lo) r = lo[SIG_BITS-1:0];
    else             r = v[SIG_BITS-1:0];
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_out(
      input logic signed [SIG_BITS-1:0] v);
    logic signed [SIG_BITS-1:0] hi;
    logic signed [SIG_BITS-1:0] lo;
    logic signed [SAMPLE_BITS-1:0] r;
    hi = {{(SIG_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    lo = ~hi;
    if (v > hi)      r = hi[SAMPLE_BITS-1:0];
    else if (v < lo) r = lo[SAMPLE_BITS-1:0];
    else             r = v[SAMPLE_BITS-1:0];
    return r;
  endfunction

endpackage

// File: hdl/stereo_biquad_eq_crossfade.sv
// stereo biquad equaliser with crossfaded band updates, top level
// sample request: each plain band runs one mac pass, each fading band a pass per filter
// plus the divider, skipped bands none (13-step mac pass per filter, 50-step fade divider)
// update request: one request at a time, next taken once idle
// reset: synchronous, clears sequencer, fade state and valid bits; no clearing pass
// depends on sbeq_pkg, sbeq_ctrl, sbeq_lane, sbeq_merge
module stereo_biquad_eq_crossfade (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [sbeq_pkg::FADE_BITS-1:0]       cfg_wdata,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // left_sample, right_sample, band, coef_b0, coef_b1, coef_b2, coef_a1, coef_a2,
  // band_active, zero fill
  input  logic [sbeq_pkg::IN_BITS-1:0]         s_tdata,
  // kind
  input  logic [0:0]                           s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // left_out, right_out
  output logic [sbeq_pkg::OUT_BITS-1:0]        m_tdata
);
  import sbeq_pkg::*;

  localparam int OFS_BAND = 2 * SAMPLE_BITS;
  localparam int OFS_COEF = OFS_BAND + BAND_W;
  localparam int OFS_ACT  = OFS_COEF + COEF_TAPS * 32;

  lane_ctl_t                   ctl;
  logic signed [COEF_BITS-1:0] coef_eff;
  logic [COEF_BITS-1:0]        coef_in [COEF_TAPS];
  logic signed [SIG_BITS-1:0]  left_x;
  logic signed [SIG_BITS-1:0]  right_x;
  logic signed [SIG_BITS-1:0]  left_res;
  logic signed [SIG_BITS-1:0]  right_res;
  logic                        push;
  logic                        out_free;

  // unpack the request fields
  assign left_x  = SIG_BITS'($signed(s_tdata[SAMPLE_BITS-1:0]));
  assign right_x = SIG_BITS'($signed(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
  always_comb begin
    for (int i = 0; i < COEF_TAPS; i++)
      coef_in[i] = s_tdata[OFS_COEF + 32*i +: COEF_BITS];
  end

  sbeq_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .s_valid     (s_tvalid),
    .s_ready     (s_tready),
    .kind        (s_tuser[0]),
    .band        (s_tdata[OFS_BAND +: BAND_W]),
    .coef_in     (coef_in),
    .band_active (s_tdata[OFS_ACT]),
    .ctl         (ctl),
    .coef_eff    (coef_eff),
    .push        (push),
    .out_free    (out_free)
  );

  sbeq_lane u_lane_left (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .coef  (coef_eff),
    .x_in  (left_x),
    .x_out (left_res)
  );

  sbeq_lane u_lane_right (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .coef  (coef_eff),
    .x_in  (right_x),
    .x_out (right_res)
  );

  sbeq_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .left_in  (left_res),
    .right_in (right_res),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// File: hdl/sbeq_lane.sv
// one channel lane: history memory, shared-step biquad mac and crossfade divider
// depends on sbeq_pkg; driven by the sequencer in sbeq_ctrl
module sbeq_lane (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sbeq_pkg::lane_ctl_t                   ctl,
  input  logic signed [sbeq_pkg::COEF_BITS-1:0] coef,
  input  logic signed [sbeq_pkg::SIG_BITS-1:0]  x_in,
  output logic signed [sbeq_pkg::SIG_BITS-1:0]  x_out
);
  import sbeq_pkg::*;

  logic [SIG_BITS-1:0] hmem [1 << HADDR_W];
  logic [BAND_COUNT-1:0] hv_cur;
  logic [BAND_COUNT-1:0] hv_old;

  logic                rd_en;
  logic [HADDR_W-1:0]  rd_addr;
  logic                wr_en;
  logic [HADDR_W-1:0]  wr_addr;
  logic [SIG_BITS-1:0] wr_data;
  logic [SIG_BITS-1:0] rd_q;
  logic                rd_vq;

  logic signed [SIG_BITS-1:0]  x;
  logic signed [SIG_BITS-1:0]  y;
  logic signed [SIG_BITS-1:0]  ycur;
  logic signed [SIG_BITS-1:0]  h0s;
  logic signed [SIG_BITS-1:0]  h2s;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [ACC_BITS-1:0]  acc;
  logic signed [NUM_BITS:0]    num;
  logic [NUM_BITS-1:0]         mag;
  logic [FADE_BITS-1:0]        rem;
  logic                        neg;

  logic signed [SIG_BITS-1:0]  hist_eff;
  logic signed [SIG_BITS-1:0]  operand;
  logic signed [ACC_BITS-1:0]  prod_a;
  logic signed [ACC_BITS-1:0]  term;
  logic signed [ACC_BITS-1:0]  shifted;
  logic signed [SIG_BITS:0]    diff;
  logic [FADE_BITS:0]          trial;
  logic                        ge;
  logic signed [NUM_BITS:0]    qs;
  logic signed [ACC_BITS-1:0]  mix_sum;
  logic                        vbit;

  // invalid history reads as zero
  assign hist_eff = rd_vq ? rd_q : '0;
  assign operand  = (ctl.step == 1) ? x : hist_eff;
  assign prod_a   = ACC_BITS'(prod);
  assign term     = (ctl.step >= 5) ? -prod_a : prod_a;
  assign shifted  = acc >>> COEF_FRAC;
  assign diff     = $signed({ycur[SIG_BITS-1], ycur}) - $signed({y[SIG_BITS-1], y});
  assign trial    = {rem, mag[NUM_BITS-1]};
  assign ge       = trial >= {1'b0, ctl.len};
  assign qs       = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign mix_sum  = ACC_BITS'(y) + ACC_BITS'(qs);
  assign vbit     = ctl.set ? hv_old[ctl.band] : hv_cur[ctl.band];
  assign x_out    = x;

  // history port decode
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (ctl.mode)
      M_PASS: begin
        if (ctl.step >= 1 && ctl.step <= 4) begin
          rd_en   = 1'b1;
          rd_addr = {ctl.set, ctl.band, HTAP_W'(ctl.step - STEP_W'(1))};
        end
        if (ctl.step == 9) begin
          wr_en = 1'b1; wr_addr = {ctl.set, ctl.band, HTAP_W'(1)}; wr_data = h0s;
        end else if (ctl.step == 10) begin
          wr_en = 1'b1; wr_addr = {ctl.set, ctl.band, HTAP_W'(3)}; wr_data = h2s;
        end else if (ctl.step == 11) begin
          wr_en = 1'b1; wr_addr = {ctl.set, ctl.band, HTAP_W'(0)}; wr_data = x;
        end else if (ctl.step == 12) begin
          wr_en = 1'b1; wr_addr = {ctl.set, ctl.band, HTAP_W'(2)}; wr_data = y;
        end
      end
      M_COPY: begin
        if (ctl.step <= 3) begin
          rd_en   = 1'b1;
          rd_addr = {1'b0, ctl.band, HTAP_W'(ctl.step)};
        end
        if (ctl.step >= 1 && ctl.step <= 4) begin
          wr_en   = 1'b1;
          wr_addr = {1'b1, ctl.band, HTAP_W'(ctl.step - STEP_W'(1))};
          wr_data = hist_eff;
        end
      end
      default: ;
    endcase
  end

  // history memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) hmem[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_q  <= hmem[rd_addr];
      rd_vq <= (ctl.mode == M_COPY) ? hv_cur[ctl.band] : vbit;
    end
  end

  // history valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      hv_cur <= '0;
      hv_old <= '0;
    end else begin
      if (ctl.mode == M_CLEAR) hv_cur[ctl.band] <= 1'b0;
      if (ctl.mode == M_PASS && ctl.step == PASS_LAST) begin
        if (ctl.set) hv_old[ctl.band] <= 1'b1;
        else         hv_cur[ctl.band] <= 1'b1;
      end
      if (ctl.mode == M_COPY && ctl.step == 4) hv_old[ctl.band] <= 1'b1;
    end
  end

  // mac, rounding and crossfade datapath
  always_ff @(posedge clk) begin
    unique case (ctl.mode)
      M_LOAD:   x <= x_in;
      M_COMMIT: x <= y;
      M_PASS: begin
        if (ctl.step >= 1 && ctl.step <= 5) prod <= coef * operand;
        if (ctl.step == 2) h0s <= hist_eff;
        if (ctl.step == 4) h2s <= hist_eff;
        if (ctl.step == 2) acc <= term;
        else if (ctl.step >= 3 && ctl.step <= 6) acc <= sat_add(acc, term);
        else if (ctl.step == 7) acc <= sat_add(acc, ACC_HALF);
        if (ctl.step == 8) y <= sat_sig(shifted);
        if (ctl.step == PASS_LAST && !ctl.set) ycur <= y;
      end
      M_MIX: begin
        if (ctl.step == 0) num <= diff * $signed({1'b0, ctl.w});
        if (ctl.step == 1) begin
          neg <= num[NUM_BITS];
          mag <= num[NUM_BITS] ? NUM_BITS'(-num) : num[NUM_BITS-1:0];
          rem <= '0;
        end
        // restoring division, one quotient bit per cycle
        if (ctl.step >= DIV_FIRST && ctl.step <= DIV_LAST) begin
          rem <= ge ? FADE_BITS'(trial - {1'b0, ctl.len}) : trial[FADE_BITS-1:0];
          mag <= {mag[NUM_BITS-2:0], ge};
        end
        if (ctl.step == MIX_LAST) x <= sat_sig(mix_sum);
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/sbeq_merge.sv
// output stage: saturates both lane results and holds the stereo result request
// depends on sbeq_pkg; fed by the lanes and the sequencer
module sbeq_merge (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  input  logic signed [sbeq_pkg::SIG_BITS-1:0] left_in,
  input  logic signed [sbeq_pkg::SIG_BITS-1:0] right_in,
  output logic                                 out_free,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [sbeq_pkg::OUT_BITS-1:0]        m_tdata
);
  import sbeq_pkg::*;

  assign out_free = !m_tvalid || m_tready;

  // result register
  always_ff @(posedge clk) begin
    if (push) m_tdata <= {sat_out(right_in), sat_out(left_in)};
  end

  always_ff @(posedge clk) begin
    if (rst)           m_tvalid <= 1'b0;
    else if (push)     m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

endmodule

// File: hdl/sbeq_ctrl.sv
// sequencer: band loop, update sweeps, fade bookkeeping and coefficient memory
// depends on sbeq_pkg; drives both sbeq_lane instances and sbeq_merge
module sbeq_ctrl (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [sbeq_pkg::FADE_BITS-1:0]         cfg_wdata,
  input  logic                                   s_valid,
  output logic                                   s_ready,
  input  logic                                   kind,
  input  logic [sbeq_pkg::BAND_W-1:0]            band,
  input  logic [sbeq_pkg::COEF_BITS-1:0]         coef_in [sbeq_pkg::COEF_TAPS],
  input  logic                                   band_active,
  output sbeq_pkg::lane_ctl_t                    ctl,
  output logic signed [sbeq_pkg::COEF_BITS-1:0]  coef_eff,
  output logic                                   push,
  input  logic                                   out_free
);
  import sbeq_pkg::*;

  state_t state, state_next;
  logic [STEP_W-1:0]    step, step_next;
  logic [BAND_W-1:0]    cur_band;
  logic [FADE_BITS-1:0] fade_length;
  logic [FADE_BITS-1:0] fade_rem [BAND_COUNT];
  logic [FADE_BITS-1:0] fade_len [BAND_COUNT];
  logic [BAND_COUNT-1:0] enabled;
  logic [BAND_COUNT-1:0] cv_cur;
  logic [BAND_COUNT-1:0] cv_old;

  logic [BAND_W-1:0]    item_band;
  logic [COEF_BITS-1:0] item_coef [COEF_TAPS];
  logic                 item_active;

  logic [COEF_BITS-1:0] cmem [1 << CADDR_W];
  logic                 c_rd_en;
  logic [CADDR_W-1:0]   c_rd_addr;
  logic                 c_wr_en;
  logic [CADDR_W-1:0]   c_wr_addr;
  logic [COEF_BITS-1:0] c_wr_data;
  logic [COEF_BITS-1:0] c_q;
  logic                 c_vq;
  logic [TAP_W-1:0]     c_tq;

  mode_t                mode;
  logic                 set_sel;
  logic [BAND_W-1:0]    sel_band;
  logic [FADE_BITS-1:0] rem_b;
  logic [FADE_BITS-1:0] len_b;
  logic                 en_b;
  logic                 accept;
  logic                 act_cancel;
  logic                 act_latch;
  logic                 act_enable;
  logic                 act_dec;
  logic                 band_inc;
  logic                 last_band;
  logic [TAP_W-1:0]     tap;

  assign accept    = s_valid && s_ready;
  assign sel_band  = (state == S_UPD || state == S_COPY || state == S_WRITE) ? item_band
                                                                            : cur_band;
  assign rem_b     = fade_rem[sel_band];
  assign len_b     = fade_len[sel_band];
  assign en_b      = enabled[sel_band];
  assign last_band = cur_band == BAND_W'(BAND_COUNT - 1);
  assign tap       = step[TAP_W-1:0];

  assign ctl.mode = mode;
  assign ctl.step = step;
  assign ctl.set  = set_sel;
  assign ctl.band = sel_band;
  assign ctl.w    = len_b - rem_b;
  assign ctl.len  = len_b;

  // identity coefficients where a set was never written
  assign coef_eff = c_vq ? c_q : ((c_tq == '0) ? COEF_ONE : '0);

  // next state and sequencer outputs
  always_comb begin
    state_next = state;
    step_next  = step;
    mode       = M_IDLE;
    set_sel    = 1'b0;
    s_ready    = 1'b0;
    push       = 1'b0;
    act_cancel = 1'b0;
    act_latch  = 1'b0;
    act_enable = 1'b0;
    act_dec    = 1'b0;
    band_inc   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_ready = 1'b1;
        if (s_valid) begin
          if (kind == KIND_UPDATE) begin
            state_next = S_UPD;
          end else begin
            mode       = M_LOAD;
            state_next = S_BAND;
          end
        end
      end
      S_UPD: begin
        step_next = '0;
        if (int'(item_band) >= BAND_COUNT) begin
          state_next = S_IDLE;
        end else if (en_b && rem_b == '0) begin
          state_next = S_COPY;
        end else begin
          if (!en_b) begin
            mode       = M_CLEAR;
            act_cancel = 1'b1;
          end
          state_next = S_WRITE;
        end
      end
      S_COPY: begin
        mode      = M_COPY;
        step_next = step + STEP_W'(1);
        if (step == STEP_W'(COPY_LAST)) begin
          act_latch  = 1'b1;
          step_next  = '0;
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        step_next = step + STEP_W'(1);
        if (step == STEP_W'(WRITE_LAST)) begin
          act_enable = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_BAND: begin
        step_next = '0;
        if (!en_b && rem_b == '0) begin
          if (last_band) state_next = S_OUT;
          else           band_inc   = 1'b1;
        end else begin
          state_next = S_PASS_CUR;
        end
      end
      S_PASS_CUR: begin
        mode      = M_PASS;
        step_next = step + STEP_W'(1);
        if (step == STEP_W'(PASS_LAST)) begin
          step_next  = '0;
          state_next = (rem_b != '0) ? S_PASS_OLD : S_NEXT;
        end
      end
      S_PASS_OLD: begin
        mode      = M_PASS;
        set_sel   = 1'b1;
        step_next = step + STEP_W'(1);
        if (step == STEP_W'(PASS_LAST)) begin
          step_next  = '0;
          state_next = S_MIX;
        end
      end
      S_MIX: begin
        mode      = M_MIX;
        step_next = step + STEP_W'(1);
        if (step == STEP_W'(MIX_LAST)) state_next = S_NEXT;
      end
      S_NEXT: begin
        // plain band output goes straight through, faded output is already in place
        if (rem_b == '0) mode = M_COMMIT;
        act_dec = 1'b1;
        if (last_band) state_next = S_OUT;
        else begin
          band_inc   = 1'b1;
          state_next = S_BAND;
        end
      end
      S_OUT: begin
        if (out_free) begin
          push       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // coefficient memory port decode
  always_comb begin
    c_rd_en   = 1'b0;
    c_rd_addr = '0;
    c_wr_en   = 1'b0;
    c_wr_addr = '0;
    c_wr_data = '0;
    if ((state == S_PASS_CUR || state == S_PASS_OLD) && step <= STEP_W'(WRITE_LAST)) begin
      c_rd_en   = 1'b1;
      c_rd_addr = {set_sel, cur_band, tap};
    end
    if (state == S_COPY) begin
      if (step <= STEP_W'(WRITE_LAST)) begin
        c_rd_en   = 1'b1;
        c_rd_addr = {1'b0, item_band, tap};
      end
      if (step >= STEP_W'(1)) begin
        c_wr_en   = 1'b1;
        c_wr_addr = {1'b1, item_band, TAP_W'(step - STEP_W'(1))};
        c_wr_data = coef_eff;
      end
    end
    if (state == S_WRITE) begin
      c_wr_en   = 1'b1;
      c_wr_addr = {1'b0, item_band, tap};
      c_wr_data = item_coef[tap];
    end
  end

  always_ff @(posedge clk) begin
    if (c_wr_en) cmem[c_wr_addr] <= c_wr_data;
    if (c_rd_en) begin
      c_q  <= cmem[c_rd_addr];
      c_tq <= c_rd_addr[TAP_W-1:0];
      c_vq <= c_rd_addr[CADDR_W-1] ? cv_old[c_rd_addr[TAP_W +: BAND_W]]
                                   : cv_cur[c_rd_addr[TAP_W +: BAND_W]];
    end
  end

  // captured update request
  always_ff @(posedge clk) begin
    if (accept) begin
      item_band   <= band;
      item_coef   <= coef_in;
      item_active <= band_active;
    end
  end

  // state, band loop and fade bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      step        <= '0;
      cur_band    <= '0;
      fade_length <= FADE_BITS'(FADE_RESET);
      enabled     <= '0;
      cv_cur      <= '0;
      cv_old      <= '0;
      for (int i = 0; i < BAND_COUNT; i++) begin
        fade_rem[i] <= '0;
        fade_len[i] <= '0;
      end
    end else begin
      state <= state_next;
      step  <= step_next;
      if (cfg_we) fade_length <= cfg_wdata;
      if (accept) cur_band <= '0;
      else if (band_inc) cur_band <= cur_band + BAND_W'(1);
      if (act_cancel) fade_rem[sel_band] <= '0;
      if (act_latch) begin
        fade_rem[sel_band] <= fade_length;
        fade_len[sel_band] <= fade_length;
        cv_old[sel_band]   <= 1'b1;
      end
      if (act_enable) begin
        enabled[sel_band] <= item_active;
        cv_cur[sel_band]  <= 1'b1;
      end
      if (act_dec && rem_b != '0) fade_rem[sel_band] <= rem_b - FADE_BITS'(1);
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !out_free) |=> (state == S_OUT))
    else $error("result dropped while output stage busy");
  a_pass_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_PASS_CUR || state == S_PASS_OLD) |-> (step <= STEP_W'(PASS_LAST)))
    else $error("pass step overran");
  a_fade_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_BAND) |-> (rem_b <= len_b))
    else $error("fade position beyond latched length");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    push |-> !s_ready)
    else $error("request accepted while a result is pushed");
`endif

endmodule

// File: tb/tb_stereo_biquad_eq_crossfade.sv
// self-checking testbench for the stereo biquad equaliser with crossfaded band updates
// holds its own bit-exact equaliser predictor; depends on sbeq_pkg and the block's top level
module tb_stereo_biquad_eq_crossfade;
  timeunit 1ns;
  timeprecision 1ps;
  import sbeq_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 50;
  localparam logic [COEF_BITS-1:0] ONE_Q = COEF_BITS'(1) << COEF_FRAC;

  typedef struct packed {
    logic                   kind;
    logic [SAMPLE_BITS-1:0] left;
    logic [SAMPLE_BITS-1:0] right;
    logic [BAND_W-1:0]      band;
    logic [4:0][COEF_BITS-1:0] coef;  // b0 b1 b2 a1 a2
    logic                   active;
  } eq_req_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] left;
    logic [SAMPLE_BITS-1:0] right;
  } stereo_out_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [FADE_BITS-1:0] cfg_wdata;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [IN_BITS-1:0]   s_tdata;
  logic [0:0]           s_tuser;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_BITS-1:0]  m_tdata;

  stereo_biquad_eq_crossfade u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // predictor state: index 0 is the live filter, 1 the saved one
  longint            eq_coef [2][BAND_COUNT][5];
  longint            eq_hist [2][BAND_COUNT][2][4];
  int unsigned       fade_left [BAND_COUNT];
  int unsigned       fade_span [BAND_COUNT];
  bit                band_on [BAND_COUNT];
  int unsigned       fade_len_reg;

  stereo_out_t       expected_out[$];
  int                mismatches = 0;
  int                quiet_cycles = 0;
  bit                gaps_on;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint add_sat64(longint a, longint b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
    return s[63:0];
  endfunction

  function automatic longint clip_bits(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // one biquad step on the live or saved filter of a band
  function automatic longint biquad_step(int sel, int b, int ch, longint x);
    longint acc;
    longint y;
    acc = eq_coef[sel][b][0] * x;
    acc = add_sat64(acc, eq_coef[sel][b][1] * eq_hist[sel][b][ch][0]);
    acc = add_sat64(acc, eq_coef[sel][b][2] * eq_hist[sel][b][ch][1]);
    acc = add_sat64(acc, -(eq_coef[sel][b][3] * eq_hist[sel][b][ch][2]));
    acc = add_sat64(acc, -(eq_coef[sel][b][4] * eq_hist[sel][b][ch][3]));
    acc = add_sat64(acc, longint'(1) <<< (COEF_FRAC - 1));
    y = clip_bits(acc >>> COEF_FRAC, SIG_BITS);
    eq_hist[sel][b][ch][1] = eq_hist[sel][b][ch][0];
    eq_hist[sel][b][ch][0] = x;
    eq_hist[sel][b][ch][3] = eq_hist[sel][b][ch][2];
    eq_hist[sel][b][ch][2] = y;
    return y;
  endfunction

  task automatic reset_equaliser_model();
    for (int s = 0; s < 2; s++)
      for (int b = 0; b < BAND_COUNT; b++) begin
        for (int t = 0; t < 5; t++) eq_coef[s][b][t] = (t == 0) ? (longint'(1) <<< COEF_FRAC) : 0;
        for (int c = 0; c < 2; c++)
          for (int t = 0; t < 4; t++) eq_hist[s][b][c][t] = 0;
      end
    for (int b = 0; b < BAND_COUNT; b++) begin
      fade_left[b] = 0;
      fade_span[b] = 0;
      band_on[b] = 1'b0;
    end
    fade_len_reg = FADE_RESET;
  endtask

  // apply one accepted request to the model, queue the stereo result if any
  task automatic predict_equaliser(eq_req_t r);
    int b;
    longint s[2];
    longint y;
    longint o;
    longint w;
    longint len;
    stereo_out_t res;
    if (r.kind == KIND_UPDATE) begin
      b = r.band;
      if (band_on[b]) begin
        if (fade_left[b] == 0) begin
          eq_coef[1][b] = eq_coef[0][b];
          eq_hist[1][b] = eq_hist[0][b];
          fade_span[b] = fade_len_reg;
          fade_left[b] = fade_len_reg;
        end
      end else begin
        fade_left[b] = 0;
        for (int c = 0; c < 2; c++)
          for (int t = 0; t < 4; t++) eq_hist[0][b][c][t] = 0;
      end
      for (int t = 0; t < 5; t++) eq_coef[0][b][t] = longint'($signed(r.coef[t]));
      band_on[b] = r.active;
    end else begin
      s[0] = longint'($signed(r.left));
      s[1] = longint'($signed(r.right));
      for (b = 0; b < BAND_COUNT; b++) begin
        if (!band_on[b] && fade_left[b] == 0) continue;
        for (int ch = 0; ch < 2; ch++) begin
          y = biquad_step(0, b, ch, s[ch]);
          if (fade_left[b] > 0) begin
            o = biquad_step(1, b, ch, s[ch]);
            len = fade_span[b];
            w = len - longint'(fade_left[b]);
            if (len > 0 && w >= 0) y = clip_bits(o + ((y - o) * w) / len, SIG_BITS);
            else y = o;
          end
          s[ch] = y;
        end
        if (fade_left[b] > 0) fade_left[b]--;
      end
      res.left  = SAMPLE_BITS'(clip_bits(s[0], SAMPLE_BITS));
      res.right = SAMPLE_BITS'(clip_bits(s[1], SAMPLE_BITS));
      expected_out.push_back(res);
    end
  endtask

  // sender: called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(eq_req_t r);
    while (gaps_on && $urandom_range(99) < 38) begin
      s_tvalid <= 1'b0;
      s_tdata  <= IN_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom});
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.kind;
    s_tdata  <= {4'b0, r.active, r.coef[4], r.coef[3], r.coef[2], r.coef[1], r.coef[0],
                 r.band, r.right, r.left};
    do @(posedge clk); while (!s_tready);
    predict_equaliser(r);
    @(negedge clk);
  endtask

  // all results in, then let an update still in flight finish
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_out.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_fade_length(int unsigned v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= FADE_BITS'(v);
    @(negedge clk);
    cfg_we    <= 1'b0;
    fade_len_reg = v & 32'h3fff;
  endtask

  function automatic eq_req_t noise_req();
    eq_req_t r;
    r.kind  = 1'($urandom_range(1));
    r.left  = SAMPLE_BITS'($urandom);
    r.right = SAMPLE_BITS'($urandom);
    r.band  = BAND_W'($urandom);
    for (int t = 0; t < 5; t++) r.coef[t] = $urandom;
    r.active = 1'($urandom_range(1));
    return r;
  endfunction

  function automatic eq_req_t sample_req(logic [SAMPLE_BITS-1:0] l, logic [SAMPLE_BITS-1:0] rr);
    eq_req_t r;
    r = noise_req();
    r.kind  = KIND_SAMPLE;
    r.left  = l;
    r.right = rr;
    return r;
  endfunction

  // well-behaved coefficients near unity gain, or fully random ones
  function automatic eq_req_t update_req(int b, bit act, bit wild);
    eq_req_t r;
    r = noise_req();
    r.kind   = KIND_UPDATE;
    r.band   = BAND_W'(b);
    r.active = act;
    if (!wild) begin
      r.coef[0] = ONE_Q + $signed($urandom_range(1 << 27)) - (1 << 26);
      r.coef[1] = $signed($urandom_range(1 << 27)) - (1 << 26);
      r.coef[2] = $signed($urandom_range(1 << 26)) - (1 << 25);
      r.coef[3] = $signed($urandom_range(1 << 27)) - (1 << 26);
      r.coef[4] = $signed($urandom_range(1 << 26)) - (1 << 25);
    end
    return r;
  endfunction

  // with no band enabled the samples pass straight through, extremes included
  task automatic test_passthrough();
    send_request(sample_req(24'h7fffff, 24'h800000));
    send_request(sample_req(24'h800000, 24'h7fffff));
    send_request(sample_req(24'h000000, 24'hffffff));
    send_request(sample_req(24'h000001, 24'h555555));
  endtask

  // enable, crossfade, update during a fade, disabled band still fading, restart
  task automatic test_band_updates();
    write_fade_length(3);
    send_request(update_req(0, 1'b1, 1'b0));
    send_request(sample_req(24'h400000, 24'hc00000));
    send_request(update_req(0, 1'b1, 1'b0));
    send_request(sample_req(24'h123456, 24'hedcba9));
    send_request(update_req(0, 1'b1, 1'b0));
    send_request(sample_req(24'h7fffff, 24'h800000));
    send_request(sample_req(24'h2aaaaa, 24'hd55555));
    send_request(sample_req(24'h000100, 24'hffff00));
    send_request(update_req(0, 1'b0, 1'b0));
    send_request(sample_req(24'h300000, 24'hd00000));
    send_request(sample_req(24'h300000, 24'hd00000));
    send_request(sample_req(24'h300000, 24'hd00000));
    send_request(sample_req(24'h300000, 24'hd00000));
    send_request(update_req(0, 1'b1, 1'b0));
    send_request(update_req(7, 1'b1, 1'b1));
    send_request(sample_req(24'h7fffff, 24'h800000));
    send_request(sample_req(24'h800000, 24'h7fffff));
  endtask

  // fade length zero: an update of an enabled band switches at once
  task automatic test_zero_fade();
    write_fade_length(0);
    send_request(update_req(7, 1'b1, 1'b0));
    send_request(sample_req(24'h654321, 24'h9abcde));
    send_request(update_req(3, 1'b1, 1'b0));
    send_request(sample_req(24'h100000, 24'hf00000));
  endtask

  // longest fade, then random phases over several fade lengths
  task automatic test_random_traffic();
    int unsigned lens[7] = '{16383, 1, 2, 5, 17, 1440, 0};
    eq_req_t r;
    for (int ph = 0; ph < 7; ph++) begin
      write_fade_length(lens[ph]);
      gaps_on = (ph != 3);
      for (int n = 0; n < 62; n++) begin
        if ($urandom_range(99) < 22)
          r = update_req($urandom_range(BAND_COUNT - 1), $urandom_range(99) < 75,
                         $urandom_range(99) < 12);
        else if ($urandom_range(99) < 85)
          r = sample_req(SAMPLE_BITS'($signed($urandom_range(1 << 22)) - (1 << 21)),
                         SAMPLE_BITS'($signed($urandom_range(1 << 22)) - (1 << 21)));
        else
          r = noise_req();
        send_request(r);
      end
    end
    gaps_on = 1'b1;
  endtask

  // sink stall pattern
  always @(negedge clk) begin
    m_tready <= gaps_on ? ($urandom_range(99) >= 38) : 1'b1;
  end

  // result checker
  always @(posedge clk) begin
    stereo_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_out.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_tdata);
      end else begin
        want = expected_out.pop_front();
        if (m_tdata[SAMPLE_BITS-1:0] !== want.left ||
            m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS] !== want.right) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected left %h right %h, got left %h right %h",
                     want.left, want.right, m_tdata[SAMPLE_BITS-1:0],
                     m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
        end
      end
    end
  end

  // watchdog on cycles without any accepted request or delivered result
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = KIND_SAMPLE;
    gaps_on = 1'b1;
    reset_equaliser_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_passthrough();
    test_band_updates();
    test_zero_fade();
    test_random_traffic();

    s_tvalid <= 1'b0;
    while (expected_out.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_out.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// File: sim.f
hdl/sbeq_pkg.sv
hdl/sbeq_lane.sv
hdl/sbeq_merge.sv
hdl/sbeq_ctrl.sv
hdl/stereo_biquad_eq_crossfade.sv
tb/tb_stereo_biquad_eq_crossfade.sv
